[src/ifd_pkg.sv]
// Shared types and constants for the IMU fall detector.
// No dependencies; every other file of the block imports this package.
package ifd_pkg;

  localparam int unsigned LvlW     = 15;  // acceleration and spin levels
  localparam int unsigned MsW      = 16;  // window and wait in ms
  localparam int unsigned TimeW    = 32;  // timestamp
  localparam int unsigned AxisW    = 16;  // one sensor axis
  localparam int unsigned AxisSqW  = 31;  // square of one axis, at most 2^30
  localparam int unsigned MagW     = 32;  // sum of three squares, below 2^32
  localparam int unsigned ThrSqW   = 2 * LvlW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PhaseW   = 2;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAddrW   = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [LvlW-1:0] FreeFallLevelRst   = 15'd2048;
  localparam logic [LvlW-1:0] ImpactLevelRst     = 15'd10240;
  localparam logic [LvlW-1:0] ImpactSpinLevelRst = 15'd2400;
  localparam logic [LvlW-1:0] RestSpinLevelRst   = 15'd240;
  localparam logic [LvlW-1:0] RestAccelLowRst    = 15'd3277;
  localparam logic [LvlW-1:0] RestAccelHighRst   = 15'd4915;
  localparam logic [MsW-1:0]  FreeFallWindowRst  = 16'd500;
  localparam logic [MsW-1:0]  SettleWaitRst      = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFreeFallLevel   = 3'd0,
    CfgImpactLevel     = 3'd1,
    CfgImpactSpinLevel = 3'd2,
    CfgRestSpinLevel   = 3'd3,
    CfgRestAccelLow    = 3'd4,
    CfgRestAccelHigh   = 3'd5,
    CfgFreeFallWindow  = 3'd6,
    CfgSettleWait      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [LvlW-1:0] free_fall_level;
    logic [LvlW-1:0] impact_level;
    logic [LvlW-1:0] impact_spin_level;
    logic [LvlW-1:0] rest_spin_level;
    logic [LvlW-1:0] rest_accel_low;
    logic [LvlW-1:0] rest_accel_high;
    logic [MsW-1:0]  free_fall_window_ms;
    logic [MsW-1:0]  settle_wait_ms;
  } cfg_t;

  // Classified sample as it travels from the front end to the phase tracker.
  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             ff_low;      // below the free-fall level
    logic             impact_hit;  // strong jolt with rotation
    logic             rest_ok;     // still and near 1 g
  } cls_t;

endpackage

[src/ifd_front.sv]
// Front end: squares the six axes, sums magnitudes and compares them with
// the squared levels. Depends on ifd_pkg.
module ifd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ifd_pkg::cfg_t                   cfg_i,
  input  logic                            take_i,
  input  logic signed [ifd_pkg::AxisW-1:0] accel_x_i,
  input  logic signed [ifd_pkg::AxisW-1:0] accel_y_i,
  input  logic signed [ifd_pkg::AxisW-1:0] accel_z_i,
  input  logic signed [ifd_pkg::AxisW-1:0] rate_x_i,
  input  logic signed [ifd_pkg::AxisW-1:0] rate_y_i,
  input  logic signed [ifd_pkg::AxisW-1:0] rate_z_i,
  input  logic [ifd_pkg::TimeW-1:0]       time_ms_i,
  output logic [1:0]                      occ_o,
  output logic                            push_o,
  output ifd_pkg::cls_t                   cls_o
);
  import ifd_pkg::*;

  function automatic logic [AxisSqW-1:0] axis_sq(input logic signed [AxisW-1:0] v);
    logic signed [2*AxisW-1:0] p;
    p = v * v;
    return p[AxisSqW-1:0];
  endfunction

  logic [ThrSqW-1:0] ffl_sq_q, imp_sq_q, ispin_sq_q, rspin_sq_q, rlo_sq_q, rhi_sq_q;

  logic               s1_valid_q;
  logic [AxisSqW-1:0] ax_sq_q, ay_sq_q, az_sq_q, gx_sq_q, gy_sq_q, gz_sq_q;
  logic [TimeW-1:0]   s1_time_q;

  logic               s2_valid_q;
  cls_t               s2_cls_q;
  cls_t               s2_cls_d;
  logic [MagW-1:0]    a2, g2;

  // Level squares are registered copies of the squared config levels.
  always_ff @(posedge clk_i) begin
    ffl_sq_q   <= cfg_i.free_fall_level * cfg_i.free_fall_level;
    imp_sq_q   <= cfg_i.impact_level * cfg_i.impact_level;
    ispin_sq_q <= cfg_i.impact_spin_level * cfg_i.impact_spin_level;
    rspin_sq_q <= cfg_i.rest_spin_level * cfg_i.rest_spin_level;
    rlo_sq_q   <= cfg_i.rest_accel_low * cfg_i.rest_accel_low;
    rhi_sq_q   <= cfg_i.rest_accel_high * cfg_i.rest_accel_high;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      ax_sq_q   <= axis_sq(accel_x_i);
      ay_sq_q   <= axis_sq(accel_y_i);
      az_sq_q   <= axis_sq(accel_z_i);
      gx_sq_q   <= axis_sq(rate_x_i);
      gy_sq_q   <= axis_sq(rate_y_i);
      gz_sq_q   <= axis_sq(rate_z_i);
      s1_time_q <= time_ms_i;
    end
    if (s1_valid_q) begin
      s2_cls_q <= s2_cls_d;
    end
  end

  always_comb begin
    a2 = MagW'(ax_sq_q) + MagW'(ay_sq_q) + MagW'(az_sq_q);
    g2 = MagW'(gx_sq_q) + MagW'(gy_sq_q) + MagW'(gz_sq_q);
    s2_cls_d.time_ms    = s1_time_q;
    s2_cls_d.ff_low     = a2 < MagW'(ffl_sq_q);
    s2_cls_d.impact_hit = (a2 > MagW'(imp_sq_q)) && (g2 > MagW'(ispin_sq_q));
    s2_cls_d.rest_ok    = (g2 < MagW'(rspin_sq_q)) && (a2 > MagW'(rlo_sq_q)) &&
                          (a2 < MagW'(rhi_sq_q));
  end

  assign occ_o  = {1'b0, s1_valid_q} + {1'b0, s2_valid_q};
  assign push_o = s2_valid_q;
  assign cls_o  = s2_cls_q;

endmodule

[src/ifd_queue.sv]
// Short queue of classified samples between the front end and the
// phase tracker. Depends on ifd_pkg.
module ifd_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  ifd_pkg::cls_t             push_data_i,
  input  logic                      pop_i,
  output logic                      nonempty_o,
  output ifd_pkg::cls_t             head_o,
  output logic [ifd_pkg::QCntW-1:0] count_o
);
  import ifd_pkg::*;

  cls_t              mem_q [QDepth];
  logic [QAddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAddrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign nonempty_o = count_q != '0;
  assign head_o     = mem_q[rd_ptr_q];
  assign count_o    = count_q;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < QCntW'(QDepth))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");
`endif

endmodule

[src/ifd_back.sv]
// Phase tracker: walks idle, free fall and impact on classified samples and
// holds the result register. Depends on ifd_pkg.
module ifd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ifd_pkg::cfg_t               cfg_i,
  input  logic                        head_valid_i,
  input  ifd_pkg::cls_t               head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        fall_confirmed_o,
  output logic [ifd_pkg::PhaseW-1:0]  phase_o
);
  import ifd_pkg::*;

  typedef enum logic [PhaseW-1:0] {
    PhIdle     = 2'd0,
    PhFreeFall = 2'd1,
    PhImpact   = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             out_valid_q;
  logic             fall_q, fall_d;
  logic [TimeW-1:0] elapsed;

  assign pop_o   = head_valid_i && (!out_valid_q || !out_stall_i);
  assign elapsed = head_i.time_ms - start_q;

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    fall_d  = 1'b0;
    case (phase_q)
      PhFreeFall: begin
        if (elapsed > TimeW'(cfg_i.free_fall_window_ms)) begin
          phase_d = PhIdle;
        end else if (head_i.impact_hit) begin
          phase_d = PhImpact;
          start_d = head_i.time_ms;
        end
      end
      PhImpact: begin
        if (elapsed > TimeW'(cfg_i.settle_wait_ms)) begin
          fall_d  = head_i.rest_ok;
          phase_d = PhIdle;
        end
      end
      default: begin
        if (head_i.ff_low) begin
          phase_d = PhFreeFall;
          start_d = head_i.time_ms;
        end else begin
          phase_d = PhIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      fall_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        start_q     <= start_d;
        fall_q      <= fall_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign fall_confirmed_o = fall_q;
  assign phase_o          = phase_q;

`ifndef SYNTH
  a_fall_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fall_q |-> phase_q == PhIdle)
    else $error("fall reported outside idle phase");

  a_impact_from_freefall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && phase_d == PhImpact && phase_q != PhImpact |-> phase_q == PhFreeFall)
    else $error("impact entered without free fall");
`endif

endmodule

[src/imu_fall_detector.sv]
// IMU fall detector top level: configuration registers, input flow control
// and the front end, queue and phase tracker. Depends on ifd_pkg.
//
// Usage: one sample per input transfer (valid high, stall low at a rising
// edge) on accel_*_i, rate_*_i and time_ms_i. Each sample yields exactly one
// result transfer on fall_confirmed_o and phase_o, in order.
// Throughput: one sample per cycle, sustained, while the output is not stalled.
// The two-stage front end (axis squares, then magnitude sums and level
// compares) feeds a four-entry queue; in_stall_o rises while four samples
// are in flight and not yet in the result register, so a stalled receiver
// backs up the input after at most five further samples. The result register
// holds its value while out_stall_i is high.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i, taken by
// the next sample; write only while no sample is in flight.
// Reset (rst_ni low, asynchronous) restores default levels, empties the
// pipeline and queue, and returns the phase to idle with start time zero.
module imu_fall_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ifd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ifd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ifd_pkg::AxisW-1:0] accel_x_i,
  input  logic signed [ifd_pkg::AxisW-1:0] accel_y_i,
  input  logic signed [ifd_pkg::AxisW-1:0] accel_z_i,
  input  logic signed [ifd_pkg::AxisW-1:0] rate_x_i,
  input  logic signed [ifd_pkg::AxisW-1:0] rate_y_i,
  input  logic signed [ifd_pkg::AxisW-1:0] rate_z_i,
  input  logic [ifd_pkg::TimeW-1:0]       time_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            fall_confirmed_o,
  output logic [ifd_pkg::PhaseW-1:0]      phase_o
);
  import ifd_pkg::*;

  cfg_t             cfg_q;
  logic             take;
  logic [1:0]       front_occ;
  logic             push;
  cls_t             push_cls;
  logic             pop;
  logic             head_valid;
  cls_t             head;
  logic [QCntW-1:0] q_count;
  logic [QCntW:0]   in_flight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.free_fall_level     <= FreeFallLevelRst;
      cfg_q.impact_level        <= ImpactLevelRst;
      cfg_q.impact_spin_level   <= ImpactSpinLevelRst;
      cfg_q.rest_spin_level     <= RestSpinLevelRst;
      cfg_q.rest_accel_low      <= RestAccelLowRst;
      cfg_q.rest_accel_high     <= RestAccelHighRst;
      cfg_q.free_fall_window_ms <= FreeFallWindowRst;
      cfg_q.settle_wait_ms      <= SettleWaitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFreeFallLevel:   cfg_q.free_fall_level     <= cfg_data_i[LvlW-1:0];
        CfgImpactLevel:     cfg_q.impact_level        <= cfg_data_i[LvlW-1:0];
        CfgImpactSpinLevel: cfg_q.impact_spin_level   <= cfg_data_i[LvlW-1:0];
        CfgRestSpinLevel:   cfg_q.rest_spin_level     <= cfg_data_i[LvlW-1:0];
        CfgRestAccelLow:    cfg_q.rest_accel_low      <= cfg_data_i[LvlW-1:0];
        CfgRestAccelHigh:   cfg_q.rest_accel_high     <= cfg_data_i[LvlW-1:0];
        CfgFreeFallWindow:  cfg_q.free_fall_window_ms <= cfg_data_i[MsW-1:0];
        CfgSettleWait:      cfg_q.settle_wait_ms      <= cfg_data_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  // Credit check: front stages plus queue entries never exceed the queue depth,
  // so the front end never has to stall.
  assign in_flight  = (QCntW + 1)'(front_occ) + (QCntW + 1)'(q_count);
  assign in_stall_o = in_flight >= (QCntW + 1)'(QDepth);
  assign take       = in_valid_i && !in_stall_o;

  ifd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .accel_x_i (accel_x_i),
    .accel_y_i (accel_y_i),
    .accel_z_i (accel_z_i),
    .rate_x_i  (rate_x_i),
    .rate_y_i  (rate_y_i),
    .rate_z_i  (rate_z_i),
    .time_ms_i (time_ms_i),
    .occ_o     (front_occ),
    .push_o    (push),
    .cls_o     (push_cls)
  );

  ifd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cls),
    .pop_i       (pop),
    .nonempty_o  (head_valid),
    .head_o      (head),
    .count_o     (q_count)
  );

  ifd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fall_confirmed_o (fall_confirmed_o),
    .phase_o          (phase_o)
  );

endmodule

[sim/tb.sv]
// Self-checking testbench for imu_fall_detector: drives sensor samples, predicts
// each result with a local phase tracker and compares every result transfer.
// Depends on ifd_pkg and the imu_fall_detector RTL.
module tb;
  import ifd_pkg::*;

  localparam logic [PhaseW-1:0] PhIdle     = 2'd0;
  localparam logic [PhaseW-1:0] PhFreeFall = 2'd1;
  localparam logic [PhaseW-1:0] PhImpact   = 2'd2;

  localparam int QuietLimit = 5000;
  localparam int DrainWait  = 10;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 90;

  typedef struct packed {
    logic signed [AxisW-1:0] ax;
    logic signed [AxisW-1:0] ay;
    logic signed [AxisW-1:0] az;
    logic signed [AxisW-1:0] rx;
    logic signed [AxisW-1:0] ry;
    logic signed [AxisW-1:0] rz;
    logic [TimeW-1:0]        t;
  } sample_t;

  typedef struct packed {
    logic              fall;
    logic [PhaseW-1:0] phase;
  } fall_res_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 fall_confirmed_o;
  logic [PhaseW-1:0]    phase_o;
  sample_t              drv_item    = '0;

  imu_fall_detector i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .accel_x_i        (drv_item.ax),
    .accel_y_i        (drv_item.ay),
    .accel_z_i        (drv_item.az),
    .rate_x_i         (drv_item.rx),
    .rate_y_i         (drv_item.ry),
    .rate_z_i         (drv_item.rz),
    .time_ms_i        (drv_item.t),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fall_confirmed_o (fall_confirmed_o),
    .phase_o          (phase_o)
  );

  // Tracker copy of the block: registers, phase and phase start time.
  logic [CfgDataW-1:0] reg_val  [8];
  logic [CfgDataW-1:0] next_cfg [8];
  logic [PhaseW-1:0]   trk_phase = PhIdle;
  logic [TimeW-1:0]    trk_start = '0;

  sample_t   pending [$];
  fall_res_t fall_q  [$];
  int        n_queued  = 0;
  int        n_taken   = 0;
  int        n_results = 0;
  int        n_bad     = 0;
  logic      in_fire   = 1'b0;
  logic      allow_idle = 1'b1;
  logic [TimeW-1:0] clock_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mag_sq(logic signed [AxisW-1:0] x,
                                         logic signed [AxisW-1:0] y,
                                         logic signed [AxisW-1:0] z);
    longint xx, yy, zz;
    xx = x;
    yy = y;
    zz = z;
    return 64'(xx * xx + yy * yy + zz * zz);
  endfunction

  function automatic logic [63:0] thr_sq(logic [CfgDataW-1:0] v);
    logic [63:0] w;
    w = {48'b0, v};
    return w * w;
  endfunction

  // Advance the phase tracker by one sample and return the result it yields.
  function automatic fall_res_t track_sample(sample_t s);
    logic [63:0]      a2, g2;
    logic [TimeW-1:0] el;
    fall_res_t        r;
    a2 = mag_sq(s.ax, s.ay, s.az);
    g2 = mag_sq(s.rx, s.ry, s.rz);
    el = s.t - trk_start;
    r.fall = 1'b0;
    case (trk_phase)
      PhFreeFall: begin
        if (el > {16'b0, reg_val[CfgFreeFallWindow]}) begin
          trk_phase = PhIdle;
        end else if (a2 > thr_sq(reg_val[CfgImpactLevel]) &&
                     g2 > thr_sq(reg_val[CfgImpactSpinLevel])) begin
          trk_phase = PhImpact;
          trk_start = s.t;
        end
      end
      PhImpact: begin
        if (el > {16'b0, reg_val[CfgSettleWait]}) begin
          r.fall = (g2 < thr_sq(reg_val[CfgRestSpinLevel])) &&
                   (a2 > thr_sq(reg_val[CfgRestAccelLow])) &&
                   (a2 < thr_sq(reg_val[CfgRestAccelHigh]));
          trk_phase = PhIdle;
        end
      end
      default: begin
        if (a2 < thr_sq(reg_val[CfgFreeFallLevel])) begin
          trk_phase = PhFreeFall;
          trk_start = s.t;
        end else begin
          trk_phase = PhIdle;
        end
      end
    endcase
    r.phase = trk_phase;
    return r;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", n_results, what, got, want);
    n_bad++;
  endtask

  // Predict on every input transfer, check on every output transfer.
  always @(posedge clk_i) begin : score
    fall_res_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        fall_q.push_back(track_sample(drv_item));
        n_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (fall_q.size() == 0) begin
          note_mismatch("result with nothing pending", phase_o, 0);
        end else begin
          want = fall_q.pop_front();
          if (fall_confirmed_o !== want.fall)
            note_mismatch("fall_confirmed", fall_confirmed_o, want.fall);
          if (phase_o !== want.phase)
            note_mismatch("phase", phase_o, want.phase);
        end
        n_results++;
      end
    end
  end

  // Sender: hold a stalled transfer, otherwise offer the next sample or idle.
  int   drv_gap = 0;
  int   drv_mode_cnt = 0;
  logic drv_bursty = 1'b1;

  always @(negedge clk_i) begin : drive_samples
    logic take_break;
    take_break = allow_idle && drv_bursty && ($urandom_range(0, 5) == 0);
    if (drv_mode_cnt == 0) begin
      drv_bursty   <= $urandom_range(0, 1);
      drv_mode_cnt <= $urandom_range(40, 160);
    end else begin
      drv_mode_cnt <= drv_mode_cnt - 1;
    end
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (drv_gap != 0) begin
        in_valid_i <= 1'b0;
        drv_gap    <= drv_gap - 1;
      end else if (pending.size() != 0 && !take_break) begin
        drv_item   <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
        if (take_break) drv_gap <= $urandom_range(0, 15);
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off to back up the input.
  int   rcv_gap = 0;
  int   hold_cnt = 0;
  logic hold_done = 1'b0;
  int   rcv_mode_cnt = 0;
  logic rcv_bursty = 1'b1;

  always @(negedge clk_i) begin : drive_stall
    if (rcv_mode_cnt == 0) begin
      rcv_bursty   <= $urandom_range(0, 1);
      rcv_mode_cnt <= $urandom_range(40, 160);
    end else begin
      rcv_mode_cnt <= rcv_mode_cnt - 1;
    end
    if (!hold_done && n_results >= 60) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= HoldCycles;
      hold_done   <= 1'b1;
    end else if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt - 1;
    end else if (rcv_gap != 0) begin
      out_stall_i <= 1'b1;
      rcv_gap     <= rcv_gap - 1;
    end else if (allow_idle && rcv_bursty && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      rcv_gap     <= $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  int quiet = 0;
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic put(int ax, int ay, int az, int rx, int ry, int rz, logic [TimeW-1:0] t);
    sample_t s;
    s.ax = ax[15:0];
    s.ay = ay[15:0];
    s.az = az[15:0];
    s.rx = rx[15:0];
    s.ry = ry[15:0];
    s.rz = rz[15:0];
    s.t  = t;
    pending.push_back(s);
    n_queued++;
  endtask

  function automatic int rnd_full();
    int r;
    r = $urandom_range(0, 65535);
    return r - 32768;
  endfunction

  // Each axis within half the level, so the magnitude stays below the level.
  function automatic int rnd_small(int lim);
    int r;
    r = $urandom_range(0, lim);
    return r - lim / 2;
  endfunction

  function automatic int pm(int v);
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic int above(int lim);
    int v;
    v = lim + $urandom_range(1, 3000);
    return (v > 32767) ? 32767 : v;
  endfunction

  // Time offset near a window limit: zero, on it, just past it, or anywhere.
  function automatic logic [TimeW-1:0] near(int lim);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return lim;
      2:       return lim + 1;
      3:       return $urandom_range(0, lim);
      default: return $urandom_range(0, 2 * lim + 2);
    endcase
  endfunction

  task automatic put_noise(logic [TimeW-1:0] t);
    put(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), t);
  endtask

  // One fall attempt: standing, free fall, jolt, settle, rest; any step may miss.
  task automatic fall_story();
    logic [TimeW-1:0] t0, t1;
    int ffl, imp, spn, rsp, rlo, rhi, win, wt, mag;
    ffl = reg_val[CfgFreeFallLevel];
    imp = reg_val[CfgImpactLevel];
    spn = reg_val[CfgImpactSpinLevel];
    rsp = reg_val[CfgRestSpinLevel];
    rlo = reg_val[CfgRestAccelLow];
    rhi = reg_val[CfgRestAccelHigh];
    win = reg_val[CfgFreeFallWindow];
    wt  = reg_val[CfgSettleWait];
    repeat ($urandom_range(0, 2)) begin
      clock_ms += $urandom_range(0, 40);
      put(rnd_small(4000), rnd_small(4000), pm($urandom_range(3000, 5000)),
          rnd_small(400), rnd_small(400), rnd_small(400), clock_ms);
    end
    t0 = clock_ms + $urandom_range(0, 50);
    put(rnd_small(ffl), rnd_small(ffl), rnd_small(ffl), rnd_full(), rnd_full(), rnd_full(), t0);
    if ($urandom_range(0, 2) == 0) put_noise(t0 + $urandom_range(0, win / 2));
    t1 = t0 + near(win);
    if ($urandom_range(0, 3) == 0)
      put(rnd_small(imp), rnd_small(imp), rnd_small(imp),
          rnd_full(), rnd_full(), rnd_full(), t1);
    else
      put(pm(above(imp)), pm($urandom_range(1, 4000)), rnd_full(),
          pm(above(spn)), pm($urandom_range(1, 4000)), rnd_full(), t1);
    if ($urandom_range(0, 2) == 0) put_noise(t1 + $urandom_range(0, wt / 2));
    mag = (rhi > rlo + 1) ? $urandom_range(rlo + 1, rhi - 1) : $urandom_range(0, 32767);
    if ($urandom_range(0, 3) == 0)
      put_noise(t1 + near(wt));
    else
      put(rnd_small(8), rnd_small(8), pm(mag),
          rnd_small(rsp), rnd_small(rsp), rnd_small(rsp), t1 + near(wt));
    clock_ms = t1 + 2 * wt + $urandom_range(3, 100);
  endtask

  task automatic run_phase(int count);
    int stop_at;
    stop_at = n_queued + count;
    clock_ms = $urandom;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 9) < 7) fall_story();
      else put_noise($urandom);
    end
  endtask

  // Wait until every sample is taken and every result is back, then settle.
  task automatic drain();
    while (n_taken != n_queued || fall_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // Write all registers back to back; only called with the block idle.
  task automatic program_regs();
    cfg_idx_e k;
    for (int i = 0; i < 8; i++) begin
      k = cfg_idx_e'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= k;
      cfg_data_i <= next_cfg[k];
      reg_val[k] = (k == CfgFreeFallWindow || k == CfgSettleWait) ?
                   next_cfg[k] : next_cfg[k] & 16'h7FFF;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_plausible();
    next_cfg[CfgFreeFallLevel]   = $urandom_range(500, 4000);
    next_cfg[CfgImpactLevel]     = $urandom_range(6000, 20000);
    next_cfg[CfgImpactSpinLevel] = $urandom_range(1000, 5000);
    next_cfg[CfgRestSpinLevel]   = $urandom_range(100, 1000);
    next_cfg[CfgRestAccelLow]    = $urandom_range(2000, 3800);
    next_cfg[CfgRestAccelHigh]   = $urandom_range(4200, 6000);
    next_cfg[CfgFreeFallWindow]  = $urandom_range(0, 800);
    next_cfg[CfgSettleWait]      = $urandom_range(0, 1500);
  endtask

  task automatic set_all(logic [CfgDataW-1:0] v);
    for (int i = 0; i < 8; i++) next_cfg[i] = v;
  endtask

  task automatic set_defaults();
    next_cfg[CfgFreeFallLevel]   = {1'b0, FreeFallLevelRst};
    next_cfg[CfgImpactLevel]     = {1'b0, ImpactLevelRst};
    next_cfg[CfgImpactSpinLevel] = {1'b0, ImpactSpinLevelRst};
    next_cfg[CfgRestSpinLevel]   = {1'b0, RestSpinLevelRst};
    next_cfg[CfgRestAccelLow]    = {1'b0, RestAccelLowRst};
    next_cfg[CfgRestAccelHigh]   = {1'b0, RestAccelHighRst};
    next_cfg[CfgFreeFallWindow]  = FreeFallWindowRst;
    next_cfg[CfgSettleWait]      = SettleWaitRst;
  endtask

  initial begin
    set_defaults();
    for (int i = 0; i < 8; i++) reg_val[i] = next_cfg[i];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed samples at reset levels.
    put(0, 0, 4096, 0, 0, 0, 10);
    put(-32768, 32767, -32768, -32768, 32767, -32768, 20);
    put(32767, -32768, 32767, 32767, -32768, 32767, 30);
    put(2048, 0, 0, 0, 0, 0, 40);              // exactly on the free-fall level
    put(2047, 0, 0, 0, 0, 0, 100);             // just below: free fall
    put(10240, 0, 0, 3000, 0, 0, 200);         // jolt exactly on the impact level
    put(12000, 0, 0, 2400, 0, 0, 300);         // spin exactly on its level
    put(16000, 0, 0, 3000, 0, 0, 600);         // last ms of the window: impact
    put(0, 0, 4096, 0, 0, 0, 1600);            // settle wait not yet exceeded
    put(0, 0, 4096, 0, 0, 0, 1601);            // rest: fall confirmed
    put(0, 0, 0, 0, 0, 0, 2000);
    put(16000, 0, 0, 3000, 0, 0, 2501);        // window ran out
    put(0, 0, 0, 0, 0, 0, 3000);
    put(0, 16000, 0, 0, -3000, 0, 3000);       // impact on the same timestamp
    put(0, 0, 4915, 0, 0, 0, 4001);            // rest on the upper bound
    put(100, -100, 0, 0, 0, 0, 5000);
    put(-16000, 0, 0, 0, 0, 3000, 5010);
    put(0, 0, 4096, 240, 0, 0, 6011);          // rest spin on its level
    put(0, 0, 0, 0, 0, 0, 7000);
    put(0, -16000, 0, 0, 3000, 0, 7001);
    put(0, 0, -3277, 0, 0, 0, 8002);           // rest on the lower bound
    put(0, 0, 0, 0, 0, 0, 32'hFFFF_FF00);      // timestamp wraps during the fall
    put(0, 0, 16000, 3000, 0, 0, 32'h0000_000A);
    put(0, 0, 4096, 0, 0, 0, 32'h0000_000A + 1001);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1:       set_all(16'h0000);
        2:       set_all(16'hFFFF);
        3: begin
          set_defaults();
          next_cfg[CfgFreeFallWindow] = '0;
          next_cfg[CfgSettleWait]     = '0;
        end
        4, 6:    for (int i = 0; i < 8; i++) next_cfg[i] = $urandom_range(0, 65535);
        default: set_plausible();
      endcase
      program_regs();
      if (p == 7) allow_idle = 1'b0;
      run_phase(PhaseItems);
      drain();
    end

    if (fall_q.size() != 0) note_mismatch("results never received", fall_q.size(), 0);
    if (n_bad == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
